>>> rtl/qaa_pkg.sv
// Shared constants, types and step functions of the quaternion to axis-angle converter.
package qaa_pkg;

   // Fixed-point format of the quaternion and axis words.
   localparam int FRAC_BITS = 14;
   localparam int WORD_W    = 16;
   localparam logic signed [WORD_W-1:0] ONE_Q     = 16'sd16384;
   localparam logic signed [WORD_W-1:0] NEG_ONE_Q = -16'sd16384;
   localparam logic [14:0] THRESH_RESET = 15'd164;

   // Integer square root unit: two radicand bits per stage.
   localparam int SQ_RAD_W  = 34;
   localparam int SQ_ROOT_W = SQ_RAD_W / 2;
   localparam int SQ_REM_W  = SQ_ROOT_W + 4;
   localparam int SQRT_LAT  = SQ_ROOT_W;

   // Rounding divider lane: one quotient bit per stage.
   localparam int DIV_NUM_W = WORD_W + FRAC_BITS;
   localparam int DIV_DEN_W = SQ_ROOT_W;
   localparam int DIV_REM_W = DIV_DEN_W + 1;
   localparam int DIV_LAT   = DIV_NUM_W;
   localparam int DIV_RES_W = DIV_NUM_W + 1;

   // CORDIC vectoring unit.
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int CD_W         = 34;
   localparam int ANG_W        = 20;
   localparam int WORK_SHIFT   = 30 - FRAC_BITS;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic [WORD_W-1:0] ANGLE_MAX = 16'd51472;

   // Pipeline layout of the top level.
   localparam int NORM_LEN  = 3 + SQRT_LAT + DIV_LAT;
   localparam int AXIS_LEN  = 3 + SQRT_LAT + DIV_LAT;
   localparam int TOTAL_LAT = NORM_LEN + AXIS_LEN;
   localparam int SINE_TAP  = 2 + SQRT_LAT;
   localparam int ANG_DLY   = DIV_LAT - CORDIC_LAT;

   typedef struct packed {
      logic signed [WORD_W-1:0] w;
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] z;
   } quat_type;

   typedef struct packed {
      quat_type q;
      logic     norm;
   } side_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
   } sq_step_type;

   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic                 qbit;
   } div_step_type;

   typedef struct packed {
      logic signed [CD_W-1:0]  x;
      logic signed [CD_W-1:0]  y;
      logic signed [ANG_W-1:0] a;
   } cordic_type;

   // One digit of the restoring square root.
   function automatic sq_step_type sqrt_step(logic [SQ_REM_W-1:0] rem,
                                             logic [SQ_ROOT_W-1:0] root,
                                             logic [1:0] pair);
      logic [SQ_REM_W-1:0] cur;
      logic [SQ_REM_W-1:0] trial;
      sq_step_type r;
      cur   = {rem[SQ_REM_W-3:0], pair};
      trial = {2'b00, root, 2'b01};
      if (cur >= trial) begin
         r.rem  = cur - trial;
         r.root = {root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur;
         r.root = {root[SQ_ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One bit of the restoring division.
   function automatic div_step_type div_step(logic [DIV_REM_W-1:0] rem,
                                             logic [DIV_DEN_W-1:0] den,
                                             logic nbit);
      logic [DIV_REM_W-1:0] cur;
      div_step_type r;
      cur = {rem[DIV_REM_W-2:0], nbit};
      if (cur >= {1'b0, den}) begin
         r.rem  = cur - {1'b0, den};
         r.qbit = 1'b1;
      end else begin
         r.rem  = cur;
         r.qbit = 1'b0;
      end
      return r;
   endfunction

   // Arctangent of 2^-i in units of 2^-16 rad.
   function automatic logic signed [ANG_W-1:0] atan_q16(int i);
      logic signed [ANG_W-1:0] v;
      unique case (i)
         0:       v = 20'sd51472;
         1:       v = 20'sd30386;
         2:       v = 20'sd16055;
         3:       v = 20'sd8150;
         4:       v = 20'sd4091;
         5:       v = 20'sd2047;
         6:       v = 20'sd1024;
         7:       v = 20'sd512;
         8:       v = 20'sd256;
         9:       v = 20'sd128;
         10:      v = 20'sd64;
         11:      v = 20'sd32;
         12:      v = 20'sd16;
         13:      v = 20'sd8;
         14:      v = 20'sd4;
         default: v = 20'sd2;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/qaa_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module qaa_isqrt (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [qaa_pkg::SQ_RAD_W-1:0]   rad_i,
   output logic [qaa_pkg::SQ_ROOT_W-1:0]  root_o
);
   import qaa_pkg::*;

   logic [SQ_RAD_W-1:0]  rad_ff  [SQRT_LAT];
   logic [SQ_REM_W-1:0]  rem_ff  [SQRT_LAT];
   logic [SQ_ROOT_W-1:0] root_ff [SQRT_LAT];
   logic [SQ_REM_W-1:0]  rem_in  [SQRT_LAT];
   logic [SQ_ROOT_W-1:0] root_in [SQRT_LAT];
   logic [SQ_RAD_W-1:0]  rad_in  [SQRT_LAT];

   // Each stage takes the next pair of radicand bits.
   always_comb begin
      logic [SQ_RAD_W-1:0]  p_rad;
      logic [SQ_REM_W-1:0]  p_rem;
      logic [SQ_ROOT_W-1:0] p_root;
      sq_step_type st;
      for (int k = 0; k < SQRT_LAT; k++) begin
         if (k == 0) begin
            p_rad  = rad_i;
            p_rem  = '0;
            p_root = '0;
         end else begin
            p_rad  = rad_ff[k-1];
            p_rem  = rem_ff[k-1];
            p_root = root_ff[k-1];
         end
         st         = sqrt_step(p_rem, p_root, p_rad[SQ_RAD_W-1-2*k -: 2]);
         rad_in[k]  = p_rad;
         rem_in[k]  = st.rem;
         root_in[k] = st.root;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root_o = root_ff[SQRT_LAT-1];

endmodule

>>> rtl/qaa_div_lane.sv
// One divider lane: rounded signed quotient q * 2^FRAC_BITS / den, one bit per stage.
module qaa_div_lane (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [qaa_pkg::WORD_W-1:0]    num_i,
   input  logic [qaa_pkg::DIV_DEN_W-1:0]        den_i,
   output logic signed [qaa_pkg::DIV_RES_W-1:0] quo_o
);
   import qaa_pkg::*;

   logic [DIV_NUM_W-1:0] m_ff   [DIV_LAT];
   logic [DIV_DEN_W-1:0] den_ff [DIV_LAT];
   logic [DIV_REM_W-1:0] rem_ff [DIV_LAT];
   logic [DIV_NUM_W-1:0] quo_ff [DIV_LAT];
   logic                 neg_ff [DIV_LAT];
   logic [DIV_NUM_W-1:0] m_in   [DIV_LAT];
   logic [DIV_DEN_W-1:0] den_in [DIV_LAT];
   logic [DIV_REM_W-1:0] rem_in [DIV_LAT];
   logic [DIV_NUM_W-1:0] quo_in [DIV_LAT];
   logic                 neg_in [DIV_LAT];
   logic [WORD_W-1:0]    mag;
   logic [DIV_NUM_W-1:0] m_start;

   // Magnitude of the scaled numerator plus half the divisor for rounding.
   assign mag     = num_i[WORD_W-1] ? WORD_W'(-num_i) : WORD_W'(num_i);
   assign m_start = {mag, {FRAC_BITS{1'b0}}}
                  + DIV_NUM_W'(den_i[DIV_DEN_W-1:1]);

   always_comb begin
      logic [DIV_NUM_W-1:0] p_m;
      logic [DIV_DEN_W-1:0] p_den;
      logic [DIV_REM_W-1:0] p_rem;
      logic [DIV_NUM_W-1:0] p_quo;
      logic                 p_neg;
      div_step_type st;
      for (int k = 0; k < DIV_LAT; k++) begin
         if (k == 0) begin
            p_m   = m_start;
            p_den = den_i;
            p_rem = '0;
            p_quo = '0;
            p_neg = num_i[WORD_W-1];
         end else begin
            p_m   = m_ff[k-1];
            p_den = den_ff[k-1];
            p_rem = rem_ff[k-1];
            p_quo = quo_ff[k-1];
            p_neg = neg_ff[k-1];
         end
         st        = div_step(p_rem, p_den, p_m[DIV_NUM_W-1-k]);
         m_in[k]   = p_m;
         den_in[k] = p_den;
         rem_in[k] = st.rem;
         quo_in[k] = {p_quo[DIV_NUM_W-2:0], st.qbit};
         neg_in[k] = p_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff   <= m_in;
         den_ff <= den_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         neg_ff <= neg_in;
      end
   end

   // Restore the sign of the numerator.
   assign quo_o = neg_ff[DIV_LAT-1] ? -$signed({1'b0, quo_ff[DIV_LAT-1]})
                                    :  $signed({1'b0, quo_ff[DIV_LAT-1]});

endmodule

>>> rtl/qaa_cordic.sv
// Pipelined CORDIC vectoring unit giving the rotation angle 2*acos(w).
module qaa_cordic (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [qaa_pkg::WORD_W-1:0] cos_i,
   input  logic [qaa_pkg::SQ_ROOT_W-1:0]     sin_i,
   output logic [qaa_pkg::WORD_W-1:0]        angle_o
);
   import qaa_pkg::*;

   cordic_type cd_ff [CORDIC_LAT];
   cordic_type cd_in [CORDIC_LAT];
   logic signed [CD_W-1:0]  x0;
   logic signed [CD_W-1:0]  y0;
   logic signed [ANG_W-1:0] a_fin;
   logic [ANG_W-1:0]        t_fin;

   assign x0 = CD_W'(cos_i) <<< WORK_SHIFT;
   assign y0 = $signed(CD_W'(sin_i)) <<< WORK_SHIFT;

   // A negative cosine is pre-rotated by a quarter turn, then the micro-rotations follow.
   always_comb begin
      cordic_type p;
      logic signed [CD_W-1:0] dx;
      logic signed [CD_W-1:0] dy;
      if (x0[CD_W-1]) begin
         cd_in[0].x = y0;
         cd_in[0].y = -x0;
         cd_in[0].a = HALF_PI_Q16;
      end else begin
         cd_in[0].x = x0;
         cd_in[0].y = y0;
         cd_in[0].a = '0;
      end
      for (int k = 1; k < CORDIC_LAT; k++) begin
         p  = cd_ff[k-1];
         dx = p.y >>> (k - 1);
         dy = p.x >>> (k - 1);
         if (!p.y[CD_W-1] && (p.y != '0)) begin
            cd_in[k].x = p.x + dx;
            cd_in[k].y = p.y - dy;
            cd_in[k].a = p.a + atan_q16(k - 1);
         end else begin
            cd_in[k].x = p.x - dx;
            cd_in[k].y = p.y + dy;
            cd_in[k].a = p.a - atan_q16(k - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff <= cd_in;
      end
   end

   // Clamp at zero, round to Q3.13 and clamp at 2*pi.
   assign a_fin = cd_ff[CORDIC_LAT-1].a;
   assign t_fin = ANG_W'((a_fin + 20'sd2) >>> 2);

   always_comb begin
      if (a_fin[ANG_W-1]) begin
         angle_o = '0;
      end else if (t_fin > ANG_W'(ANGLE_MAX)) begin
         angle_o = ANGLE_MAX;
      end else begin
         angle_o = t_fin[WORD_W-1:0];
      end
   end

endmodule

>>> rtl/quat_to_axis_angle_top.sv
// Top level of the quaternion to axis-angle converter.
// A fully pipelined converter: it takes one quaternion in every cycle while the output is not
// held, and gives one result per quaternion, in order.
// The pipeline is built from two 17-stage square-root units and two banks of 30-stage
// divider lanes (four lanes normalize, three divide the axis), with the 17-stage
// CORDIC running beside the axis lanes. The whole pipeline holds while a result
// waits under rsp_stall, and req_stall is raised only then. The threshold register
// is written through the csr_ channel, which is always ready.
module quat_to_axis_angle_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qaa_pkg::WORD_W-1:0]  req_quat_w,
   input  logic signed [qaa_pkg::WORD_W-1:0]  req_quat_x,
   input  logic signed [qaa_pkg::WORD_W-1:0]  req_quat_y,
   input  logic signed [qaa_pkg::WORD_W-1:0]  req_quat_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [qaa_pkg::WORD_W-1:0]         rsp_angle,
   output logic signed [qaa_pkg::WORD_W-1:0]  rsp_axis_x,
   output logic signed [qaa_pkg::WORD_W-1:0]  rsp_axis_y,
   output logic signed [qaa_pkg::WORD_W-1:0]  rsp_axis_z,
   output logic                               rsp_small_sine,
   output logic                               rsp_was_normalised,
   output logic                               rsp_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [14:0]                        csr_small_sine_threshold
);
   import qaa_pkg::*;

   logic adv;
   logic [14:0] thr_ff;
   logic        vld_ff [TOTAL_LAT];
   quat_type    qa_ff  [NORM_LEN];
   side_type    sb_ff  [AXIS_LEN];
   side_type    sb_in;
   logic [31:0] sq_ff  [4];
   logic [32:0] sum_ff;
   logic [28:0] w2_ff;
   logic [28:0] rad_ff;
   logic [SQ_ROOT_W-1:0] mag;
   logic [SQ_ROOT_W-1:0] sine;
   logic [SQ_ROOT_W-1:0] s_dly  [DIV_LAT];
   logic [WORD_W-1:0]    ang_dly [ANG_DLY];
   logic [WORD_W-1:0]    ang_cd;
   logic signed [DIV_RES_W-1:0] nq  [4];
   logic signed [DIV_RES_W-1:0] aq  [3];
   logic signed [31:0] sq_w, sq_x, sq_y, sq_z, w2_p;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        angle_ff, angle_in;
   logic signed [WORD_W-1:0] axis_ff [3];
   logic signed [WORD_W-1:0] axis_in [3];
   logic small_ff, small_in, norm_ff, norm_in, sat_ff, sat_in;

   // The pipeline moves unless a result is held at the output.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_small_sine_threshold;
      end
   end

   // Valid bits along the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) vld_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < TOTAL_LAT; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = vld_ff[TOTAL_LAT-1];

   // Squares for the magnitude.
   assign sq_w = qa_ff[0].w * qa_ff[0].w;
   assign sq_x = qa_ff[0].x * qa_ff[0].x;
   assign sq_y = qa_ff[0].y * qa_ff[0].y;
   assign sq_z = qa_ff[0].z * qa_ff[0].z;
   assign w2_p = sb_ff[0].q.w * sb_ff[0].q.w;

   // Raw quaternion line up to the end of normalization, and the arithmetic beside it.
   always_ff @(posedge clock) begin
      if (adv) begin
         qa_ff[0] <= '{w: req_quat_w, x: req_quat_x, y: req_quat_y, z: req_quat_z};
         for (int k = 1; k < NORM_LEN; k++) qa_ff[k] <= qa_ff[k-1];
         sq_ff[0] <= sq_w;
         sq_ff[1] <= sq_x;
         sq_ff[2] <= sq_y;
         sq_ff[3] <= sq_z;
         sum_ff   <= 33'(sq_ff[0]) + 33'(sq_ff[1]) + 33'(sq_ff[2]) + 33'(sq_ff[3]);
      end
   end

   qaa_isqrt u_mag (
      .clock  (clock),
      .adv    (adv),
      .rad_i  (SQ_RAD_W'(sum_ff)),
      .root_o (mag)
   );

   // Four normalization lanes.
   qaa_div_lane u_norm_w (.clock(clock), .adv(adv), .num_i(qa_ff[2+SQRT_LAT].w),
                          .den_i(mag), .quo_o(nq[0]));
   qaa_div_lane u_norm_x (.clock(clock), .adv(adv), .num_i(qa_ff[2+SQRT_LAT].x),
                          .den_i(mag), .quo_o(nq[1]));
   qaa_div_lane u_norm_y (.clock(clock), .adv(adv), .num_i(qa_ff[2+SQRT_LAT].y),
                          .den_i(mag), .quo_o(nq[2]));
   qaa_div_lane u_norm_z (.clock(clock), .adv(adv), .num_i(qa_ff[2+SQRT_LAT].z),
                          .den_i(mag), .quo_o(nq[3]));

   // Merge the normalization lanes and clamp w at minus one.
   always_comb begin
      quat_type r;
      r = qa_ff[NORM_LEN-1];
      sb_in.norm = (r.w > ONE_Q);
      if (sb_in.norm) begin
         sb_in.q.w = nq[0][WORD_W-1:0];
         sb_in.q.x = nq[1][WORD_W-1:0];
         sb_in.q.y = nq[2][WORD_W-1:0];
         sb_in.q.z = nq[3][WORD_W-1:0];
      end else begin
         sb_in.q = r;
      end
      if (sb_in.q.w < NEG_ONE_Q) begin
         sb_in.q.w = NEG_ONE_Q;
      end
   end

   // Sideband line through the sine and axis stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= sb_in;
         for (int k = 1; k < AXIS_LEN; k++) sb_ff[k] <= sb_ff[k-1];
         w2_ff  <= w2_p[28:0];
         rad_ff <= 29'd268435456 - w2_ff;
         s_dly[0] <= sine;
         for (int k = 1; k < DIV_LAT; k++) s_dly[k] <= s_dly[k-1];
         ang_dly[0] <= ang_cd;
         for (int k = 1; k < ANG_DLY; k++) ang_dly[k] <= ang_dly[k-1];
      end
   end

   qaa_isqrt u_sine (
      .clock  (clock),
      .adv    (adv),
      .rad_i  (SQ_RAD_W'(rad_ff)),
      .root_o (sine)
   );

   qaa_cordic u_cordic (
      .clock   (clock),
      .adv     (adv),
      .cos_i   (sb_ff[SINE_TAP].q.w),
      .sin_i   (sine),
      .angle_o (ang_cd)
   );

   // Three axis lanes.
   qaa_div_lane u_axis_x (.clock(clock), .adv(adv), .num_i(sb_ff[SINE_TAP].q.x),
                          .den_i(sine), .quo_o(aq[0]));
   qaa_div_lane u_axis_y (.clock(clock), .adv(adv), .num_i(sb_ff[SINE_TAP].q.y),
                          .den_i(sine), .quo_o(aq[1]));
   qaa_div_lane u_axis_z (.clock(clock), .adv(adv), .num_i(sb_ff[SINE_TAP].q.z),
                          .den_i(sine), .quo_o(aq[2]));

   // Merge the axis lanes: pass-through on a small sine, otherwise saturate out-of-range quotients.
   always_comb begin
      logic [WORD_W-1:0] comp [3];
      logic any_sat;
      side_type e;
      e = sb_ff[AXIS_LEN-1];
      comp[0] = e.q.x;
      comp[1] = e.q.y;
      comp[2] = e.q.z;
      any_sat = 1'b0;
      small_in = (s_dly[DIV_LAT-1] == '0)
              || (s_dly[DIV_LAT-1] < SQ_ROOT_W'(thr_ff));
      for (int i = 0; i < 3; i++) begin
         if (small_in) begin
            axis_in[i] = comp[i];
         end else if (aq[i] > DIV_RES_W'(32767)) begin
            axis_in[i] = 16'sh7FFF;
            any_sat    = 1'b1;
         end else if (aq[i] < -DIV_RES_W'(32768)) begin
            axis_in[i] = -16'sh8000;
            any_sat    = 1'b1;
         end else begin
            axis_in[i] = aq[i][WORD_W-1:0];
         end
      end
      sat_in   = any_sat;
      norm_in  = e.norm;
      angle_in = ang_dly[ANG_DLY-1];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
         axis_ff  <= axis_in;
         small_ff <= small_in;
         norm_ff  <= norm_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_angle          = angle_ff;
   assign rsp_axis_x         = axis_ff[0];
   assign rsp_axis_y         = axis_ff[1];
   assign rsp_axis_z         = axis_ff[2];
   assign rsp_small_sine     = small_ff;
   assign rsp_was_normalised = norm_ff;
   assign rsp_saturated      = sat_ff;

endmodule

>>> tb/quat_to_axis_angle_top_test.sv
// Testbench of the quaternion to axis-angle converter: directed cases, threshold sweeps,
// random quaternions and receiver hold-off, checked against a bit-exact predictor.
`timescale 1ns / 1ps

module quat_to_axis_angle_top_test;
   import qaa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 130;
   localparam int IDLE_PERCENT = 21;

   // One predicted axis-angle result.
   typedef struct {
      logic [15:0]        angle;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic               small_sine;
      logic               normalised;
      logic               saturated;
   } axis_angle_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [15:0] req_quat_w, req_quat_x, req_quat_y, req_quat_z;
   logic rsp_valid;
   logic rsp_stall;
   logic [15:0] rsp_angle;
   logic signed [15:0] rsp_axis_x, rsp_axis_y, rsp_axis_z;
   logic rsp_small_sine, rsp_was_normalised, rsp_saturated;
   logic csr_valid;
   logic csr_ready;
   logic [14:0] csr_small_sine_threshold;

   axis_angle_type pending_results[$];
   longint unsigned sine_threshold;
   bit idle_enable;
   int hold_left;
   int error_count;
   int cycle_count;
   int quats_sent;
   int results_seen;
   int small_sine_seen, normalised_seen, saturated_seen;

   quat_to_axis_angle_top dut (.*);

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of the square root.
   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // Division rounded to nearest, ties away from zero.
   function automatic longint round_div(longint num, longint den);
      longint m;
      longint q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   // Angle acos(c) as atan2(s, c) in units of 2^-16 rad.
   function automatic longint cordic_acos(longint c, longint s);
      longint cx, cy, ang, dx, dy, t;
      cx = c <<< WORK_SHIFT;
      cy = s <<< WORK_SHIFT;
      ang = 0;
      if (cx < 0) begin
         t = cx;
         cx = cy;
         cy = -t;
         ang = HALF_PI_Q16;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx += dx;
            cy -= dy;
            ang += atan_q16(i);
         end else begin
            cx -= dx;
            cy += dy;
            ang -= atan_q16(i);
         end
      end
      return ang;
   endfunction

   // Axis-angle result that one quaternion should produce.
   function automatic axis_angle_type predict_axis_angle(logic signed [15:0] w,
                                                        logic signed [15:0] x,
                                                        logic signed [15:0] y,
                                                        logic signed [15:0] z);
      axis_angle_type r;
      longint q[4];
      longint one, mag, s, ang, theta, v;
      longint unsigned sum;
      one = longint'(1) << FRAC_BITS;
      q[0] = w;
      q[1] = x;
      q[2] = y;
      q[3] = z;
      r.normalised = 1'b0;
      r.small_sine = 1'b0;
      r.saturated = 1'b0;
      if (q[0] > one) begin
         sum = 0;
         for (int i = 0; i < 4; i++) sum += q[i] * q[i];
         mag = int_sqrt(sum);
         for (int i = 0; i < 4; i++) q[i] = round_div(q[i] * one, mag);
         r.normalised = 1'b1;
      end
      if (q[0] < -one) q[0] = -one;
      s = int_sqrt(one * one - q[0] * q[0]);
      ang = cordic_acos(q[0], s);
      if (ang < 0) ang = 0;
      theta = (ang + 2) >>> 2;
      if (theta > ANGLE_MAX) theta = ANGLE_MAX;
      r.angle = theta[15:0];
      // Pass the axis through when the sine is too small to divide by.
      if (s == 0 || s < longint'(sine_threshold)) begin
         r.small_sine = 1'b1;
         for (int i = 1; i < 4; i++) q[i] = q[i];
      end else begin
         for (int i = 1; i < 4; i++) begin
            v = round_div(q[i] * one, s);
            if (v > 32767) begin
               v = 32767;
               r.saturated = 1'b1;
            end else if (v < -32768) begin
               v = -32768;
               r.saturated = 1'b1;
            end
            q[i] = v;
         end
      end
      r.ax = q[1][15:0];
      r.ay = q[2][15:0];
      r.az = q[3][15:0];
      return r;
   endfunction

   // Prints one mismatch and counts it.
   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch at result %0d: %s got %0d, wanted %0d", results_seen, what, got, want);
   endtask

   // Sends one quaternion and records its predicted result on transfer.
   task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_axis_angle(w, x, y, z));
      quats_sent++;
   endtask

   // Waits until every predicted result has arrived and the pipeline is empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the threshold register through its own channel.
   task automatic write_threshold(logic [14:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_small_sine_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sine_threshold = value;
   endtask

   // One random component: full range, near plus or minus one, or near zero.
   function automatic logic signed [15:0] random_word();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'(16384 - $urandom_range(0, 700) + $urandom_range(0, 40));
         2:       return 16'(-16384 + $urandom_range(0, 700) - $urandom_range(0, 40));
         default: return 16'(int'($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   // A random quaternion, mostly built from random components, some of it raw noise.
   task automatic send_random_quat();
      logic signed [15:0] w;
      int pick;
      pick = $urandom_range(9);
      w = random_word();
      if (pick < 6) begin
         send_quat(w, random_word(), random_word(), random_word());
      end else begin
         send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // Extremes of each field and the special cases at the reset threshold.
   task automatic test_directed();
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_quat(-16'sd16384, 16'sd100, -16'sd100, 16'sd5);
      send_quat(16'sd32767, 16'sd32767, -16'sd32768, 16'sd1);
      send_quat(16'sd16385, 16'sd0, 16'sd0, 16'sd0);
      send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      send_quat(16'sd0, 16'sd32767, -16'sd32768, -16'sd1);
      send_quat(16'sd16380, 16'sd32767, -16'sd32768, 16'sd1000);
      send_quat(16'sd16383, 16'sd50, -16'sd50, 16'sd0);
      send_quat(-16'sd16383, -16'sd32768, 16'sd32767, 16'sd0);
      send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
      send_quat(-16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
      send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
      send_quat(16'sd20000, -16'sd20000, 16'sd20000, -16'sd20000);
      send_quat(16'sd1, -16'sd1, 16'sd16384, -16'sd16384);
      send_quat(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
   endtask

   // Sweeps the threshold through zero, 16384, its maximum, one, a random value and the reset value.
   task automatic test_thresholds();
      logic [14:0] sweep[6];
      sweep = '{15'd0, 15'd16384, 15'h7fff, 15'd1, 15'($urandom), THRESH_RESET};
      foreach (sweep[k]) begin
         write_threshold(sweep[k]);
         send_quat(16'sd16384, 16'sd7, -16'sd7, 16'sd0);
         send_quat(16'sd16383, 16'sd300, 16'sd0, -16'sd300);
         send_quat(16'sd0, 16'sd8000, -16'sd8000, 16'sd1);
         repeat (40) send_random_quat();
      end
   endtask

   // Bulk random quaternions, with one stretch where neither side idles.
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         idle_enable = !(i >= count / 3 && i < count / 3 + 300);
         send_random_quat();
      end
      idle_enable = 1'b1;
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering quaternions.
   task automatic test_backpressure();
      hold_left = 400;
      repeat (200) send_random_quat();
   endtask

   // Hold-off counter of the receiver.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Receiver stall: random idling plus any hold-off in progress.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_left > 1) || (idle_enable && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      axis_angle_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_angle !== want.angle) report_mismatch("angle", rsp_angle, want.angle);
            if (rsp_axis_x !== want.ax) report_mismatch("axis_x", rsp_axis_x, want.ax);
            if (rsp_axis_y !== want.ay) report_mismatch("axis_y", rsp_axis_y, want.ay);
            if (rsp_axis_z !== want.az) report_mismatch("axis_z", rsp_axis_z, want.az);
            if (rsp_small_sine !== want.small_sine)
               report_mismatch("small_sine", rsp_small_sine, want.small_sine);
            if (rsp_was_normalised !== want.normalised)
               report_mismatch("was_normalised", rsp_was_normalised, want.normalised);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", rsp_saturated, want.saturated);
            small_sine_seen += want.small_sine;
            normalised_seen += want.normalised;
            saturated_seen += want.saturated;
         end
         results_seen++;
      end
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_quat_w = '0;
      req_quat_x = '0;
      req_quat_y = '0;
      req_quat_z = '0;
      csr_valid = 1'b0;
      csr_small_sine_threshold = '0;
      sine_threshold = THRESH_RESET;
      idle_enable = 1'b1;
      hold_left = 0;
      error_count = 0;
      cycle_count = 0;
      quats_sent = 0;
      results_seen = 0;
      small_sine_seen = 0;
      normalised_seen = 0;
      saturated_seen = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_thresholds();
      test_random(1376);
      test_backpressure();
      drain_results();

      if (pending_results.size() != 0) report_mismatch("results missing", 0, 1);
      $display("Sent %0d quaternions, checked %0d results across six threshold settings.",
               quats_sent, results_seen);
      $display("Small-sine %0d, normalized %0d, saturated %0d.",
               small_sine_seen, normalised_seen, saturated_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
